@@ src/uapq_pkg.sv @@
// ----------------------------------------------------------------------------
// uapq_pkg
// Shared types and codes for the unsorted-array priority queue: beat
// payloads, result status codes, operation codes and the controller states.
// ----------------------------------------------------------------------------
`default_nettype none

package uapq_pkg;

   // Operation codes carried in the request beat
   localparam logic OP_ENQUEUE = 1'b0;
   localparam logic OP_DEQUEUE = 1'b1;

   // Result status codes
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   // Width of the capacity register and of the reported occupancy
   localparam int CAP_WIDTH = 6;
   localparam logic [CAP_WIDTH-1:0] CAP_RESET = 6'd32;

   typedef struct packed {
      logic               op;
      logic signed [31:0] key_in;
      logic signed [31:0] priority_in;
   } req_type;

   typedef struct packed {
      logic signed [31:0]    key_out;
      logic [1:0]            status;
      logic [CAP_WIDTH-1:0]  occupancy;
   } rsp_type;

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SCAN,
      ST_SCAN_WAIT,
      ST_SHIFT_SETUP,
      ST_SHIFT,
      ST_SHIFT_WAIT,
      ST_FINISH
   } state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic load_req;
      logic ptr_clear;
      logic ptr_load_best;
      logic rd_scan;
      logic rd_shift;
      logic commit;
   } cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic op;
      logic queue_empty;
      logic ptr_at_last;
      logic shift_none;
      logic rsp_free;
   } stat_type;

endpackage

`default_nettype wire

@@ src/uapq_ram.sv @@
// ----------------------------------------------------------------------------
// uapq_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module uapq_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ src/uapq_ctrl.sv @@
// ----------------------------------------------------------------------------
// uapq_ctrl
// Sequencer for the priority queue: decodes a request beat, steps the
// minimum scan and the shift-down, and commits the result.
// ----------------------------------------------------------------------------
`default_nettype none

module uapq_ctrl
   import uapq_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_stall,
   input  wire stat_type stat,
   output cmd_type       cmd
);

   state_type state_ff;
   state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load_req  = 1'b1;
               cmd.ptr_clear = 1'b1;
               state_in      = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (stat.op == OP_DEQUEUE && !stat.queue_empty) begin
               state_in = ST_SCAN;
            end else begin
               state_in = ST_FINISH;
            end
         end
         // Issue one read per cycle over the held entries
         ST_SCAN: begin
            cmd.rd_scan = 1'b1;
            if (stat.ptr_at_last) begin
               state_in = ST_SCAN_WAIT;
            end
         end
         // Last compare lands this cycle
         ST_SCAN_WAIT: begin
            state_in = ST_SHIFT_SETUP;
         end
         ST_SHIFT_SETUP: begin
            cmd.ptr_load_best = 1'b1;
            if (stat.shift_none) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_SHIFT;
            end
         end
         // Read entry i+1, write it to i on the next cycle
         ST_SHIFT: begin
            cmd.rd_shift = 1'b1;
            if (stat.ptr_at_last) begin
               state_in = ST_SHIFT_WAIT;
            end
         end
         ST_SHIFT_WAIT: begin
            state_in = ST_FINISH;
         end
         // Commit once the output register can take the beat
         ST_FINISH: begin
            if (stat.rsp_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

@@ src/uapq_dpath.sv @@
// ----------------------------------------------------------------------------
// uapq_dpath
// Datapath for the priority queue: entry RAM, occupancy and capacity
// registers, scan pointer, running minimum and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module uapq_dpath
   import uapq_pkg::*;
#(
   parameter int DEPTH = 32
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire req_type              req_data,
   output rsp_type                   rsp_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   input  wire logic                 csr_wr_en,
   input  wire logic [CAP_WIDTH-1:0] csr_wr_data,
   input  wire cmd_type              cmd,
   output stat_type                  stat
);

   localparam int AW   = $clog2(DEPTH);
   localparam int CW   = $clog2(DEPTH + 1);
   localparam int CMPW = (CW > CAP_WIDTH) ? CW : CAP_WIDTH;
   localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);

   // Request payload
   logic               op_ff;
   logic signed [31:0] key_ff;
   logic signed [31:0] prio_ff;

   // Control registers
   logic [CW-1:0]        count_ff, count_in;
   logic [CAP_WIDTH-1:0] cap_ff;
   logic [AW-1:0]        ptr_ff, ptr_in;
   logic                 rd_scan_ff, rd_shift_ff;
   logic [AW-1:0]        rd_idx_ff;
   logic                 rsp_valid_ff;

   // Running minimum
   logic [AW-1:0]      best_idx_ff;
   logic signed [31:0] best_prio_ff;
   logic signed [31:0] best_key_ff;

   rsp_type rsp_data_ff, rsp_data_in;

   // RAM ports
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [63:0]        wr_data;
   logic               rd_en;
   logic [63:0]        rd_data;
   logic signed [31:0] rd_key;
   logic signed [31:0] rd_prio;

   logic          queue_full;
   logic          queue_empty;
   logic [CW-1:0] count_m1;
   logic [CW-1:0] best_p1;

   assign queue_empty = (count_ff == '0);
   assign queue_full  = (count_ff == DEPTH_CNT) ||
                        (CMPW'(count_ff) >= CMPW'(cap_ff));
   assign count_m1    = count_ff - 1'b1;
   assign best_p1     = CW'(best_idx_ff) + 1'b1;

   assign rd_key  = rd_data[63:32];
   assign rd_prio = rd_data[31:0];

   // Status toward the controller
   always_comb begin
      stat.op          = op_ff;
      stat.queue_empty = queue_empty;
      stat.ptr_at_last = (CW'(ptr_ff) == count_m1);
      stat.shift_none  = (best_p1 == count_ff);
      stat.rsp_free    = !rsp_valid_ff || !rsp_stall;
   end

   // Capture the request beat
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff   <= req_data.op;
         key_ff  <= req_data.key_in;
         prio_ff <= req_data.priority_in;
      end
   end

   // Capacity register
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else if (csr_wr_en) begin
         cap_ff <= csr_wr_data;
      end
   end

   // Scan and shift pointer
   always_comb begin
      ptr_in = ptr_ff;
      if (cmd.ptr_clear) begin
         ptr_in = '0;
      end else if (cmd.ptr_load_best) begin
         ptr_in = AW'(best_p1);
      end else if (cmd.rd_scan || cmd.rd_shift) begin
         ptr_in = ptr_ff + 1'b1;
      end
   end

   assign rd_en = cmd.rd_scan || cmd.rd_shift;

   // Track which read is in flight
   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff      <= '0;
         rd_scan_ff  <= 1'b0;
         rd_shift_ff <= 1'b0;
      end else begin
         ptr_ff      <= ptr_in;
         rd_scan_ff  <= cmd.rd_scan;
         rd_shift_ff <= cmd.rd_shift;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_idx_ff <= ptr_ff;
      end
   end

   // Keep the earliest entry with the smallest priority
   always_ff @(posedge clock) begin
      if (rd_scan_ff && (rd_idx_ff == '0 || rd_prio < best_prio_ff)) begin
         best_idx_ff  <= rd_idx_ff;
         best_prio_ff <= rd_prio;
         best_key_ff  <= rd_key;
      end
   end

   // Write port: shift-down writes or the enqueue append
   always_comb begin
      if (rd_shift_ff) begin
         wr_en   = 1'b1;
         wr_addr = rd_idx_ff - 1'b1;
         wr_data = rd_data;
      end else begin
         wr_en   = cmd.commit && (op_ff == OP_ENQUEUE) && !queue_full;
         wr_addr = AW'(count_ff);
         wr_data = {key_ff, prio_ff};
      end
   end

   uapq_ram #(
      .WIDTH (64),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (ptr_ff),
      .rd_data (rd_data)
   );

   // Result and new occupancy at commit
   always_comb begin
      count_in            = count_ff;
      rsp_data_in.key_out = '0;
      rsp_data_in.status  = STATUS_OK;
      if (op_ff == OP_ENQUEUE) begin
         if (queue_full) begin
            rsp_data_in.status = STATUS_FULL;
         end else begin
            count_in = count_ff + 1'b1;
         end
      end else begin
         if (queue_empty) begin
            rsp_data_in.status = STATUS_EMPTY;
         end else begin
            count_in            = count_m1;
            rsp_data_in.key_out = best_key_ff;
         end
      end
      rsp_data_in.occupancy = CAP_WIDTH'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.commit) begin
         count_ff <= count_in;
      end
   end

   // Output register: load on commit, drop when the beat is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

@@ src/unsorted_array_priority_queue.sv @@
// ----------------------------------------------------------------------------
// unsorted_array_priority_queue
// Priority queue of (key, priority) entries kept unsorted in one RAM.
// ----------------------------------------------------------------------------
// An enqueue appends at the tail, or reports full once the occupancy reaches
// the capacity register (saturated at DEPTH). A dequeue reads every held
// entry through the single RAM read port to find the smallest signed
// priority (earliest on ties), then moves each later entry down one place,
// one entry per cycle through the same port; a dequeue on an empty queue
// reports empty. One request is handled at a time; the result sits in an
// output register, and the next request is taken as soon as the previous
// one has been committed to it. Every result reports the occupancy after
// the operation.
// ----------------------------------------------------------------------------
`default_nettype none

module unsorted_array_priority_queue
   import uapq_pkg::*;
#(
   parameter int DEPTH = 32
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire req_type              req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output rsp_type                   rsp_data,
   input  wire logic                 csr_wr_en,
   input  wire logic [CAP_WIDTH-1:0] csr_wr_data
);

   cmd_type  cmd;
   stat_type stat;

   // Sequencer
   uapq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Storage and arithmetic
   uapq_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .rsp_data    (rsp_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .stat        (stat)
   );

endmodule

`default_nettype wire

@@ sim/uapq_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// uapq_checker
// Scoreboard for the unsorted-array priority queue. It watches the request,
// response and capacity ports and keeps its own copy of the held entries.
// For every accepted request beat it computes the response the queue must
// give. Each accepted response beat is then compared field by field against
// the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module uapq_checker
   import uapq_pkg::*;
#(
   parameter int DEPTH = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  req_type              req_data,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  rsp_type              rsp_data,
   input  logic                 csr_wr_en,
   input  logic [CAP_WIDTH-1:0] csr_wr_data,
   output int                   mismatch_count,
   output int                   pending_count,
   output int                   checked_count,
   output int                   full_count,
   output int                   empty_count,
   output int                   peak_occupancy
);

   // Shadow copy of the queue contents and the capacity register
   logic signed [31:0]   held_key [DEPTH];
   logic signed [31:0]   held_prio [DEPTH];
   int                   held_count;
   logic [CAP_WIDTH-1:0] capacity;
   rsp_type              expected_rsp_q[$];

   // Apply one request to the shadow queue and return the response it earns
   function automatic rsp_type serve_request(input req_type beat);
      rsp_type rsp;
      int      limit;
      int      best;
      rsp.key_out = '0;
      rsp.status  = STATUS_OK;
      limit = (capacity > DEPTH) ? DEPTH : int'(capacity);
      if (beat.op == OP_ENQUEUE) begin
         if (held_count >= limit) begin
            rsp.status = STATUS_FULL;
         end else begin
            held_key[held_count]  = beat.key_in;
            held_prio[held_count] = beat.priority_in;
            held_count++;
         end
      end else if (held_count == 0) begin
         rsp.status = STATUS_EMPTY;
      end else begin
         // Find the smallest priority; strict compare keeps the earliest on ties
         best = 0;
         for (int i = 1; i < held_count; i++) begin
            if (held_prio[i] < held_prio[best]) begin
               best = i;
            end
         end
         rsp.key_out = held_key[best];
         // Close the gap: move only held entries down by one
         for (int i = best; i < held_count - 1; i++) begin
            held_key[i]  = held_key[i + 1];
            held_prio[i] = held_prio[i + 1];
         end
         held_count--;
      end
      rsp.occupancy = held_count[CAP_WIDTH-1:0];
      if (held_count > peak_occupancy) begin
         peak_occupancy = held_count;
      end
      return rsp;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         held_count     = 0;
         capacity       = CAP_RESET;
         mismatch_count = 0;
         checked_count  = 0;
         full_count     = 0;
         empty_count    = 0;
         peak_occupancy = 0;
         expected_rsp_q.delete();
      end else begin
         if (csr_wr_en) begin
            capacity = csr_wr_data;
         end
         // Check the response beat first: it always belongs to an older request
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp_q.size() == 0) begin
               $display("%0t: unexpected response beat key_out=%h status=%0d occupancy=%0d",
                        $time, rsp_data.key_out, rsp_data.status, rsp_data.occupancy);
               mismatch_count++;
            end else begin
               want = expected_rsp_q.pop_front();
               checked_count++;
               if (rsp_data.key_out !== want.key_out) begin
                  $display("%0t: key_out mismatch expected %h actual %h",
                           $time, want.key_out, rsp_data.key_out);
                  mismatch_count++;
               end
               if (rsp_data.status !== want.status) begin
                  $display("%0t: status mismatch expected %0d actual %0d",
                           $time, want.status, rsp_data.status);
                  mismatch_count++;
               end
               if (rsp_data.occupancy !== want.occupancy) begin
                  $display("%0t: occupancy mismatch expected %0d actual %0d",
                           $time, want.occupancy, rsp_data.occupancy);
                  mismatch_count++;
               end
               if (want.status == STATUS_FULL) begin
                  full_count++;
               end
               if (want.status == STATUS_EMPTY) begin
                  empty_count++;
               end
            end
         end
         // Predict the response for an accepted request beat
         if (req_valid && !req_stall) begin
            expected_rsp_q.push_back(serve_request(req_data));
         end
      end
      pending_count <= expected_rsp_q.size();
   end

endmodule

@@ sim/unsorted_array_priority_queue_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// unsorted_array_priority_queue_tb
// Stimulus and verdict for the unsorted-array priority queue. A short directed
// sequence hits the empty and full cases, extreme keys and priorities and
// priority ties. Randomized phases then follow under several capacity
// settings, with fill-heavy and drain-heavy runs and random back-pressure.
// Checking is done by uapq_checker.
// ----------------------------------------------------------------------------
module unsorted_array_priority_queue_tb;
   import uapq_pkg::*;

   localparam int DEPTH        = 32;
   localparam int WATCHDOG_MAX = 2000;
   localparam int SETTLE_TIME  = 2 * DEPTH + 16;

   localparam logic signed [31:0] EXTREME_PRIO [4] = '{
      32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0000_0000, -32'sd1
   };

   logic                 clock       = 1'b0;
   logic                 reset       = 1'b1;
   logic                 req_valid   = 1'b0;
   req_type              req_data    = '0;
   logic                 rsp_stall   = 1'b0;
   logic                 csr_wr_en   = 1'b0;
   logic [CAP_WIDTH-1:0] csr_wr_data = '0;
   logic                 req_stall;
   logic                 rsp_valid;
   rsp_type              rsp_data;

   int mismatch_count;
   int pending_count;
   int checked_count;
   int full_count;
   int empty_count;
   int peak_occupancy;
   int gap_pct     = 0;
   int stall_pct   = 0;
   int quiet_count = 0;
   int requests_sent = 0;

   always #6 clock = ~clock;

   unsorted_array_priority_queue #(
      .DEPTH(DEPTH)
   ) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   uapq_checker #(
      .DEPTH(DEPTH)
   ) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count),
      .checked_count  (checked_count),
      .full_count     (full_count),
      .empty_count    (empty_count),
      .peak_occupancy (peak_occupancy)
   );

   // Watchdog: give up once no beat has moved for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_count <= 0;
      end else if (quiet_count == WATCHDOG_MAX) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         quiet_count <= quiet_count + 1;
      end
   end

   // Response back-pressure: random stall bursts of random length
   initial begin
      forever begin
         @(posedge clock);
         if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 14)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Present one request beat, with an optional idle burst ahead of it;
   // hold it until accepted
   task automatic send_beat(input req_type beat);
      if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      requests_sent++;
   endtask

   task automatic enqueue(input logic signed [31:0] key, input logic signed [31:0] prio);
      req_type beat;
      beat.op          = OP_ENQUEUE;
      beat.key_in      = key;
      beat.priority_in = prio;
      send_beat(beat);
   endtask

   // Dequeue with junk in the key and priority fields, which must be ignored
   task automatic dequeue();
      req_type beat;
      beat.op          = OP_DEQUEUE;
      beat.key_in      = $urandom;
      beat.priority_in = $urandom;
      send_beat(beat);
   endtask

   // Stop sending and wait until every predicted response has come back
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [CAP_WIDTH-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // One random phase: alternate fill-heavy and drain-heavy runs so the queue
   // swings between empty and full
   task automatic run_phase(input logic [CAP_WIDTH-1:0] cap, input int count,
                            input int idle_pct);
      req_type beat;
      int      enq_pct;
      int      run_left;
      drain();
      write_capacity(cap);
      gap_pct   = idle_pct;
      stall_pct = idle_pct;
      enq_pct   = 85;
      run_left  = $urandom_range(8, 48);
      for (int n = 0; n < count; n++) begin
         if (run_left == 0) begin
            enq_pct  = (enq_pct > 50) ? 20 : 85;
            run_left = $urandom_range(8, 48);
         end
         run_left--;
         beat.op     = ($urandom_range(0, 99) < enq_pct) ? OP_ENQUEUE : OP_DEQUEUE;
         beat.key_in = $urandom;
         // Mix narrow ranges (many ties), extremes and full-range priorities
         case ($urandom_range(0, 3))
            0:       beat.priority_in = $signed($urandom_range(0, 8)) - 4;
            1:       beat.priority_in = EXTREME_PRIO[$urandom_range(0, 3)];
            default: beat.priority_in = $urandom;
         endcase
         send_beat(beat);
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Empty queue, extreme keys and priorities, ties, at reset capacity
      dequeue();
      enqueue(32'sh8000_0000, 32'sh7FFF_FFFF);
      enqueue(32'sh7FFF_FFFF, 32'sh8000_0000);
      enqueue(32'sh0000_0000, 32'sh0000_0000);
      enqueue(-32'sd1, -32'sd1);
      enqueue(32'sd5, 32'sh8000_0000);
      enqueue(32'sd6, 32'sh0000_0000);
      repeat (7) dequeue();

      // Capacity of one: second enqueue is refused
      drain();
      write_capacity(6'd1);
      enqueue(32'sd11, 32'sd3);
      enqueue(32'sd12, -32'sd3);
      dequeue();
      dequeue();

      // Capacity of zero: every enqueue is refused
      drain();
      write_capacity(6'd0);
      enqueue(32'sd13, 32'sd0);
      dequeue();

      // Random phases over a spread of capacities and idle rates
      run_phase(6'd63, 130, 20);
      run_phase(6'd32, 130, 0);
      run_phase(6'd1,   60, 30);
      run_phase(6'd17, 110, 10);
      run_phase(6'd0,   40, 20);
      run_phase(6'd2,   80, 30);
      run_phase(6'd32, 150, 30);
      run_phase(6'd40, 150, 0);

      drain();
      repeat (SETTLE_TIME) @(posedge clock);

      $display("Sent %0d requests at capacities 0, 1, 2, 17, 32, 40 and 63; %0d checked.",
               requests_sent, checked_count);
      $display("Refused as full: %0d, refused as empty: %0d, peak occupancy: %0d.",
               full_count, empty_count, peak_occupancy);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
